// ===== hdl/vfa_pkg.sv =====
// types and constants for the fixed-point 3-vector unit
// used by vfa_sqrt_cell, vfa_div_cell and vec3_fixed_point_alu; no dependencies
`default_nettype none

package vfa_pkg;

    localparam int ROOT_BITS = 32;
    localparam int QUO_BITS  = 32;

    typedef enum logic [2:0] {
        OP_MAG   = 3'd0,
        OP_NORM  = 3'd1,
        OP_TRUNC = 3'd2,
        OP_DOT   = 3'd3,
        OP_CROSS = 3'd4
    } op_t;

    // item carried down the pipe; er/esc hold results settled early
    typedef struct packed {
        logic [2:0]        op;
        logic [2:0][31:0]  a;
        logic [30:0]       limit;
        logic [2:0][31:0]  er;
        logic [31:0]       esc;
    } item_t;

    typedef struct packed {
        item_t                 item;
        logic [63:0]           rem;
        logic [ROOT_BITS-1:0]  root;
    } sqrt_t;

    typedef struct packed {
        item_t                       item;
        logic [2:0][63:0]            rem;
        logic [2:0][QUO_BITS-1:0]    q;
        logic [31:0]                 den;
        logic                        use_div;
    } div_t;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -66'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vec3_fixed_point_alu.sv =====
// fixed-point 3-vector unit: magnitude, normalize, truncate, dot, cross
// depends on vfa_pkg, vfa_sqrt_cell, vfa_div_cell
//
//   channel | signals                                  | dir
//   in      | in_valid in_ready op ax ay az bx by bz limit | sink
//   out     | out_valid out_ready rx ry rz scalar      | source
//
// one beat per cycle; stages: capture, products, sums,
// 32 root cells, scale multiply, 32 divider cells, output register
// the whole chain advances together; it holds while a result waits
// and out_ready is low
// reset clears the valid bits only
`default_nettype none

module vec3_fixed_point_alu #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         op,
    input  wire logic signed [31:0] ax,
    input  wire logic signed [31:0] ay,
    input  wire logic signed [31:0] az,
    input  wire logic signed [31:0] bx,
    input  wire logic signed [31:0] by,
    input  wire logic signed [31:0] bz,
    input  wire logic [30:0]        limit,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      rx,
    output logic signed [31:0]      ry,
    output logic signed [31:0]      rz,
    output logic signed [31:0]      scalar
);

    localparam int NR = vfa_pkg::ROOT_BITS;
    localparam int NQ = vfa_pkg::QUO_BITS;
    localparam logic [31:0] ONE_FIX = 32'(1) << FRAC_BITS;

    logic en;

    // capture stage
    logic                v0_reg;
    vfa_pkg::item_t      it0_reg;
    logic signed [31:0]  b0_reg [3];

    // product stage
    logic                v1_reg;
    vfa_pkg::item_t      it1_reg;
    logic signed [31:0]  ma [6];
    logic signed [31:0]  mb [6];
    logic signed [63:0]  p_reg [6];

    // sum stage
    logic                vs_reg;
    vfa_pkg::sqrt_t      sq_reg;
    vfa_pkg::sqrt_t      sq_next;
    logic [63:0]         sumsq;
    logic signed [65:0]  dotsum;
    logic signed [64:0]  cd [3];

    logic                sq_v [NR+1];
    vfa_pkg::sqrt_t      sq_d [NR+1];

    // scale stage
    logic                vm_reg;
    vfa_pkg::div_t       dm_reg;
    vfa_pkg::div_t       dm_next;
    logic [31:0]         num;
    logic [31:0]         amag [3];

    logic                dv_v [NQ+1];
    vfa_pkg::div_t       dv_d [NQ+1];

    // output stage
    logic                out_valid_reg;
    logic [31:0]         r_reg [3];
    logic [31:0]         sc_reg;
    logic [31:0]         r_next [3];
    logic [31:0]         sc_next;
    logic signed [32:0]  sq_val;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            vs_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= v0_reg;
            vs_reg        <= v1_reg;
            vm_reg        <= sq_v[NR];
            out_valid_reg <= dv_v[NQ];
        end
    end

    // operand selection for the six multipliers
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ma[i] = it0_reg.a[i];
            mb[i] = it0_reg.a[i];
        end
        for (int i = 3; i < 6; i++)
        begin
            ma[i] = '0;
            mb[i] = '0;
        end
        case (it0_reg.op)
            vfa_pkg::OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                    mb[i] = b0_reg[i];
            end
            vfa_pkg::OP_CROSS:
            begin
                ma[0] = it0_reg.a[1]; mb[0] = b0_reg[2];
                ma[1] = it0_reg.a[2]; mb[1] = b0_reg[1];
                ma[2] = it0_reg.a[2]; mb[2] = b0_reg[0];
                ma[3] = it0_reg.a[0]; mb[3] = b0_reg[2];
                ma[4] = it0_reg.a[0]; mb[4] = b0_reg[1];
                ma[5] = it0_reg.a[1]; mb[5] = b0_reg[0];
            end
            default:
            begin
            end
        endcase
    end

    // sums of the products, dot and cross settled here
    always_comb
    begin
        sumsq  = 64'(p_reg[0]) + 64'(p_reg[1]) + 64'(p_reg[2]);
        dotsum = 66'(p_reg[0]) + 66'(p_reg[1]) + 66'(p_reg[2]);
        cd[0]  = 65'(p_reg[0]) - 65'(p_reg[1]);
        cd[1]  = 65'(p_reg[2]) - 65'(p_reg[3]);
        cd[2]  = 65'(p_reg[4]) - 65'(p_reg[5]);
        sq_next          = '0;
        sq_next.item     = it1_reg;
        sq_next.item.er  = '0;
        sq_next.item.esc = '0;
        sq_next.rem      = sumsq;
        case (it1_reg.op)
            vfa_pkg::OP_DOT:
                sq_next.item.esc = vfa_pkg::sat32(dotsum >>> FRAC_BITS);
            vfa_pkg::OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                    sq_next.item.er[i] = vfa_pkg::sat32(66'(cd[i]) >>> FRAC_BITS);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it0_reg.op    <= op;
            it0_reg.a[0]  <= ax;
            it0_reg.a[1]  <= ay;
            it0_reg.a[2]  <= az;
            it0_reg.limit <= limit;
            it0_reg.er    <= '0;
            it0_reg.esc   <= '0;
            b0_reg[0]     <= bx;
            b0_reg[1]     <= by;
            b0_reg[2]     <= bz;
            it1_reg       <= it0_reg;
            for (int i = 0; i < 6; i++)
                p_reg[i] <= ma[i] * mb[i];
            sq_reg        <= sq_next;
            dm_reg        <= dm_next;
            for (int i = 0; i < 3; i++)
                r_reg[i] <= r_next[i];
            sc_reg        <= sc_next;
        end
    end

    assign sq_v[0] = vs_reg;
    assign sq_d[0] = sq_reg;

    for (genvar j = 0; j < NR; j++)
    begin : g_root
        vfa_sqrt_cell #(
            .K (NR - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[j]),
            .in_data   (sq_d[j]),
            .out_valid (sq_v[j+1]),
            .out_data  (sq_d[j+1])
        );
    end

    // scale numerators, the magnitude result and the choice between divided and plain A
    always_comb
    begin
        num = (sq_d[NR].item.op == vfa_pkg::OP_NORM) ? ONE_FIX
                                                      : {1'b0, sq_d[NR].item.limit};
        dm_next      = '0;
        dm_next.item = sq_d[NR].item;
        dm_next.den  = sq_d[NR].root;
        for (int i = 0; i < 3; i++)
        begin
            amag[i] = sq_d[NR].item.a[i][31] ? (~sq_d[NR].item.a[i] + 32'd1)
                                             : sq_d[NR].item.a[i];
            dm_next.rem[i] = {32'b0, amag[i]} * {32'b0, num};
        end
        case (sq_d[NR].item.op)
            vfa_pkg::OP_MAG:
                dm_next.item.esc = sq_d[NR].root[NR-1] ? 32'h7fff_ffff : sq_d[NR].root;
            vfa_pkg::OP_NORM:
                dm_next.use_div = (sq_d[NR].root != '0);
            vfa_pkg::OP_TRUNC:
                dm_next.use_div = (sq_d[NR].root > {1'b0, sq_d[NR].item.limit});
            default:
            begin
            end
        endcase
    end

    assign dv_v[0] = vm_reg;
    assign dv_d[0] = dm_reg;

    for (genvar j = 0; j < NQ; j++)
    begin : g_quo
        vfa_div_cell #(
            .K (NQ - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[j]),
            .in_data   (dv_d[j]),
            .out_valid (dv_v[j+1]),
            .out_data  (dv_d[j+1])
        );
    end

    // restore signs and pick the result
    always_comb
    begin
        sq_val  = '0;
        sc_next = dv_d[NQ].item.esc;
        for (int i = 0; i < 3; i++)
            r_next[i] = dv_d[NQ].item.er[i];
        if (dv_d[NQ].item.op == vfa_pkg::OP_NORM || dv_d[NQ].item.op == vfa_pkg::OP_TRUNC)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_d[NQ].use_div)
                begin
                    sq_val = dv_d[NQ].item.a[i][31] ? -$signed({1'b0, dv_d[NQ].q[i]})
                                                    : $signed({1'b0, dv_d[NQ].q[i]});
                    r_next[i] = vfa_pkg::sat32(66'(sq_val));
                end
                else
                    r_next[i] = dv_d[NQ].item.a[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign rx        = r_reg[0];
    assign ry        = r_reg[1];
    assign rz        = r_reg[2];
    assign scalar    = sc_reg;

endmodule

`default_nettype wire

// ===== hdl/vfa_sqrt_cell.sv =====
// one bit of the integer square root, restoring form
// depends on vfa_pkg
`default_nettype none

module vfa_sqrt_cell #(
    parameter int K = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire vfa_pkg::sqrt_t in_data,
    output logic               out_valid,
    output vfa_pkg::sqrt_t     out_data
);

    logic           valid_reg;
    vfa_pkg::sqrt_t data_reg;
    vfa_pkg::sqrt_t data_next;
    logic [65:0]    trial;
    logic [65:0]    remx;

    always_comb
    begin
        // trial = 2*root*2^K + 2^(2K), root holding only bits above K
        trial = ({34'b0, in_data.root} << (K + 1)) + (66'(1) << (2 * K));
        remx  = {2'b0, in_data.rem};
        data_next = in_data;
        if (remx >= trial)
        begin
            data_next.rem  = 64'(remx - trial);
            data_next.root = in_data.root | (vfa_pkg::ROOT_BITS'(1) << K);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/vfa_div_cell.sv =====
// one quotient bit for each of the three component dividers
// depends on vfa_pkg
`default_nettype none

module vfa_div_cell #(
    parameter int K = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire vfa_pkg::div_t in_data,
    output logic               out_valid,
    output vfa_pkg::div_t      out_data
);

    logic          valid_reg;
    vfa_pkg::div_t data_reg;
    vfa_pkg::div_t data_next;
    logic [63:0]   trial;

    always_comb
    begin
        trial     = {32'b0, in_data.den} << K;
        data_next = in_data;
        for (int i = 0; i < 3; i++)
        begin
            if (in_data.rem[i] >= trial)
            begin
                data_next.rem[i] = in_data.rem[i] - trial;
                data_next.q[i]   = in_data.q[i] | (vfa_pkg::QUO_BITS'(1) << K);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== tb/vec3_fixed_point_alu_tb.sv =====
// testbench for vec3_fixed_point_alu: queue-fed driver with a self-contained
// predictor for magnitude, normalize, truncate, dot, cross, and a checking monitor
// depends on vfa_pkg and the vec3_fixed_point_alu rtl
`default_nettype none

module vec3_fixed_point_alu_tb;

    localparam int FRAC        = 16;
    localparam int DRAIN       = 200;
    localparam int WATCHDOG    = 5000;
    localparam int NUM_RANDOM  = 1000;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic [30:0]        lim;
    } vec_item_t;

    typedef struct {
        logic signed [31:0] r [3];
        logic signed [31:0] sc;
    } vec_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         op;
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic [30:0]        limit;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] rx, ry, rz, scalar;

    vec_item_t pending_items [$];
    vec_res_t  expected_results [$];
    vec_item_t offered;
    int        errors;
    int        beats_in;
    int        beats_out;
    int        in_gap;
    int        out_gap;
    int        hold_off;
    bit        hold_done;
    bit        burst_mode;
    int        idle_cycles;

    vec3_fixed_point_alu #(.FRAC_BITS(FRAC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
        .limit(limit),
        .out_valid(out_valid), .out_ready(out_ready),
        .rx(rx), .ry(ry), .rz(rz), .scalar(scalar)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        logic signed [31:0] r;
        if (v > 128'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (v < -128'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] vec_length(input vec_item_t it);
        logic [63:0]        acc;
        logic signed [63:0] c;
        acc = 64'd0;
        for (int i = 0; i < 3; i++) begin
            c = it.a[i];
            acc = acc + 64'(c * c);
        end
        return int_sqrt(acc);
    endfunction

    // |c|*num/den toward zero, magnitude capped at 2^31 before the sign
    function automatic logic signed [127:0] scaled_comp(input logic signed [31:0] c,
                                                        input logic [63:0] num,
                                                        input logic [63:0] den);
        logic signed [63:0] cw;
        logic [63:0]        m;
        logic [63:0]        q;
        cw = c;
        m = (cw < 0) ? 64'(-cw) : 64'(cw);
        q = (m * num) / den;
        if (q > 64'h8000_0000)
            q = 64'h8000_0000;
        return (c < 0) ? -$signed({64'd0, q}) : $signed({64'd0, q});
    endfunction

    function automatic logic signed [127:0] wprod(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
        logic signed [127:0] xw, yw;
        xw = x;
        yw = y;
        return xw * yw;
    endfunction

    function automatic vec_res_t compute_vector_op(input vec_item_t it);
        vec_res_t            res;
        logic [63:0]         len;
        logic signed [127:0] w [3];
        logic signed [127:0] s;
        for (int i = 0; i < 3; i++)
            w[i] = 0;
        s = 0;
        case (it.op)
            vfa_pkg::OP_MAG:
                s = $signed({64'd0, vec_length(it)});
            vfa_pkg::OP_NORM: begin
                len = vec_length(it);
                for (int i = 0; i < 3; i++)
                    w[i] = (len == 0) ? 128'(it.a[i])
                                      : scaled_comp(it.a[i], 64'd1 << FRAC, len);
            end
            vfa_pkg::OP_TRUNC: begin
                len = vec_length(it);
                for (int i = 0; i < 3; i++)
                    w[i] = (len > 64'(it.lim)) ? scaled_comp(it.a[i], 64'(it.lim), len)
                                              : 128'(it.a[i]);
            end
            vfa_pkg::OP_DOT:
                s = (wprod(it.a[0], it.b[0]) + wprod(it.a[1], it.b[1])
                     + wprod(it.a[2], it.b[2])) >>> FRAC;
            vfa_pkg::OP_CROSS: begin
                w[0] = (wprod(it.a[1], it.b[2]) - wprod(it.a[2], it.b[1])) >>> FRAC;
                w[1] = (wprod(it.a[2], it.b[0]) - wprod(it.a[0], it.b[2])) >>> FRAC;
                w[2] = (wprod(it.a[0], it.b[1]) - wprod(it.a[1], it.b[0])) >>> FRAC;
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++)
            res.r[i] = clamp32(w[i]);
        res.sc = clamp32(s);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        else if (r < 5)
            return ($urandom_range(0, 1) == 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        return $signed($urandom());
    endfunction

    task automatic add_item(input logic [2:0] o,
                            input logic signed [31:0] a0, a1, a2, b0, b1, b2,
                            input logic [30:0] l);
        vec_item_t it;
        it.op = o;
        it.a[0] = a0; it.a[1] = a1; it.a[2] = a2;
        it.b[0] = b0; it.b[1] = b1; it.b[2] = b2;
        it.lim = l;
        pending_items.push_back(it);
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(compute_vector_op(offered));
                beats_in++;
                if (beats_in % 100 == 0)
                    burst_mode = ($urandom_range(0, 3) == 0);
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0) begin
                    offered = pending_items.pop_front();
                    op    <= offered.op;
                    ax    <= offered.a[0];
                    ay    <= offered.a[1];
                    az    <= offered.a[2];
                    bx    <= offered.b[0];
                    by    <= offered.b[1];
                    bz    <= offered.b[2];
                    limit <= offered.lim;
                    in_valid <= 1'b1;
                    in_gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        vec_res_t exp_r;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                beats_out++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end
                else begin
                    exp_r = expected_results.pop_front();
                    if (rx !== exp_r.r[0]) begin
                        $display("%0t: rx expected %h actual %h", $time, exp_r.r[0], rx);
                        errors++;
                    end
                    if (ry !== exp_r.r[1]) begin
                        $display("%0t: ry expected %h actual %h", $time, exp_r.r[1], ry);
                        errors++;
                    end
                    if (rz !== exp_r.r[2]) begin
                        $display("%0t: rz expected %h actual %h", $time, exp_r.r[2], rz);
                        errors++;
                    end
                    if (scalar !== exp_r.sc) begin
                        $display("%0t: scalar expected %h actual %h",
                                 $time, exp_r.sc, scalar);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && beats_in >= 300) begin
                // long back-pressure so the pipe fills and in_ready drops
                hold_done = 1'b1;
                hold_off = 300;
                out_ready <= 1'b0;
            end
            else if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("[vec3_fixed_point_alu] ERROR");
                $finish;
            end
        end
    end

    initial begin
        vec_item_t it;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        in_gap = 0;
        out_gap = 0;
        hold_off = 0;
        hold_done = 1'b0;
        burst_mode = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        op = vfa_pkg::OP_MAG;
        {ax, ay, az, bx, by, bz} = '0;
        limit = '0;

        // directed: zero vectors, extremes, each op, special cases
        add_item(vfa_pkg::OP_MAG, 0, 0, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_MAG, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 0, 0, 0, 0);
        add_item(vfa_pkg::OP_MAG, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 0, 0, 0, 0);
        add_item(vfa_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_NORM, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_NORM, 32'sh8000_0000, 0, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_TRUNC, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0,
                 31'h0005_0000);
        add_item(vfa_pkg::OP_TRUNC, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0,
                 31'h0001_0000);
        add_item(vfa_pkg::OP_TRUNC, 32'sh8000_0000, 32'sh7fff_ffff, 1, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_TRUNC, 32'sh8000_0000, 32'sh7fff_ffff, -1, 0, 0, 0,
                 31'h7fff_ffff);
        add_item(vfa_pkg::OP_TRUNC, 0, 0, 0, 0, 0, 0, 0);
        add_item(vfa_pkg::OP_DOT, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                 32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000, 0);
        add_item(vfa_pkg::OP_DOT, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        add_item(vfa_pkg::OP_DOT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0);
        add_item(vfa_pkg::OP_DOT, -1, 0, 0, 1, 0, 0, 0);
        add_item(vfa_pkg::OP_CROSS, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0, 0);
        add_item(vfa_pkg::OP_CROSS, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        add_item(vfa_pkg::OP_CROSS, -1, 1, -1, 1, 1, 1, 0);
        add_item(3'd5, -1, -1, -1, -1, -1, -1, 31'h7fff_ffff);
        add_item(3'd6, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0);
        add_item(3'd7, 32'sh0001_0000, 0, 0, 0, 0, 0, 0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            it.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            for (int i = 0; i < 3; i++) begin
                it.a[i] = rand_comp();
                it.b[i] = rand_comp();
            end
            // zero length now and then
            if ($urandom_range(0, 24) == 0)
                for (int i = 0; i < 3; i++)
                    it.a[i] = 0;
            case ($urandom_range(0, 3))
                0: it.lim = 31'($urandom_range(0, 32'h0008_0000));
                1: it.lim = ($urandom_range(0, 1)) ? 31'h7fff_ffff : 31'd0;
                default: it.lim = 31'($urandom());
            endcase
            pending_items.push_back(it);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("[vec3_fixed_point_alu] OK");
        else
            $display("[vec3_fixed_point_alu] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
